### design/dpd_pkg.sv
// ----------------------------------------------------------------------------
// Debug packet deframer package
// Character codes, packet phases, result kinds and the hex digit decoder
// shared by the deframer and (result kinds only) its checker.
// ----------------------------------------------------------------------------
package dpd_pkg;

	// Framing characters
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_ACK   = 8'h2B;
	localparam logic [7:0] CH_NAK   = 8'h2D;
	localparam logic [6:0] CH_SEQ   = 7'h3A;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_TX      = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// Results one byte can cause
	localparam int unsigned MAX_RES = 4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA,
		PH_HIGH,
		PH_LOW
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       ok;
		logic       last;
	} res_t;

	// Decode one hex digit; anything else reads as minus one
	function automatic logic signed [4:0] hex_value(input logic [7:0] c);
		logic signed [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h41 + 8'd10);
		end else begin
			v = -5'sd1;
		end
		return v;
	endfunction

endpackage

### design/debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// Debug packet deframer
// Hunts for '$', streams 7-bit payload, checks the two hex digit checksum
// after '#', then answers '+' (with sequence echo) or '-' and an end marker.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with rx_byte, one raw link byte per
//   request. Output channel: out_valid / out_stall with kind, data,
//   packet_ok and last; last marks the final result of one input byte.
//   Path: a byte lands in the input register; once the result buffer is
//   free, its results (up to four) are built in one pass and loaded into
//   the result buffer, which presents the first result.
//   Draining: the buffer drains one result per cycle while out_stall is
//   low; bytes with no result pass without entering it. The most results,
//   four, come from the low checksum digit of a good packet with a
//   sequence prefix.
//   A new byte is taken while the previous results still drain.
//   Stall: while out_stall is high the current result holds; the input
//   register and then in_stall back up behind it.
//   Reset: arst_n clears the phase, checksum and prefix flags and empties
//   both registers; the held prefix bytes need no reset.
// ----------------------------------------------------------------------------
module debug_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic       packet_ok,
	output logic       last
);

	// Input register
	logic       vld_s1;
	logic [7:0] rx_s1;

	// Packet state
	dpd_pkg::phase_t   phase_q, phase_d;
	logic [7:0]        sum_q, sum_d;
	logic [1:0]        pcount_q, pcount_d;
	logic [6:0]        prefix_q [2];
	logic              prefix_we;
	logic              seq_q, seq_d;
	logic signed [4:0] high_q, high_d;

	// Result buffer
	dpd_pkg::res_t res_q [dpd_pkg::MAX_RES];
	dpd_pkg::res_t res_d [dpd_pkg::MAX_RES];
	logic [2:0]    n_d;
	logic          busy_q;
	logic [1:0]    rd_q;

	logic       pop, pop_last, buf_free, s1_move, in_take;
	logic [6:0] b7;
	logic [7:0] pre0, pre1;
	logic signed [9:0] chk;

	// Handshake
	assign pop      = busy_q && !out_stall;
	assign pop_last = pop && res_q[rd_q].last;
	assign buf_free = !busy_q || pop_last;
	assign s1_move  = vld_s1 && buf_free;
	assign in_stall = vld_s1 && !buf_free;
	assign in_take  = in_valid && !in_stall;

	assign out_valid = busy_q;
	assign kind      = res_q[rd_q].kind;
	assign data      = res_q[rd_q].data;
	assign packet_ok = res_q[rd_q].ok;
	assign last      = res_q[rd_q].last;

	assign b7   = rx_s1[6:0];
	assign pre0 = {1'b0, prefix_q[0]};
	assign pre1 = {1'b0, prefix_q[1]};
	assign chk  = $signed({2'b00, sum_q}) - ($signed({{5{high_q[4]}}, high_q}) <<< 4)
	              - $signed({{5{1'b0}}, 5'b0}) - 10'(dpd_pkg::hex_value(rx_s1));

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			dpd_pkg::PH_IDLE: begin
				if (rx_s1 == dpd_pkg::CH_START) phase_d = dpd_pkg::PH_DATA;
			end
			dpd_pkg::PH_DATA: begin
				if (rx_s1 == dpd_pkg::CH_END) phase_d = dpd_pkg::PH_HIGH;
			end
			dpd_pkg::PH_HIGH: phase_d = dpd_pkg::PH_LOW;
			dpd_pkg::PH_LOW:  phase_d = dpd_pkg::PH_IDLE;
			default:          phase_d = dpd_pkg::PH_IDLE;
		endcase
	end

	// Build the results and the packet state for the byte in the input register
	always_comb begin
		for (int i = 0; i < dpd_pkg::MAX_RES; i++) begin
			res_d[i] = '{kind: dpd_pkg::KIND_PAYLOAD, data: 8'd0, ok: 1'b0, last: 1'b0};
		end
		n_d       = 3'd0;
		sum_d     = sum_q;
		pcount_d  = pcount_q;
		prefix_we = 1'b0;
		seq_d     = seq_q;
		high_d    = high_q;
		case (phase_q)
			dpd_pkg::PH_IDLE: begin
			end
			dpd_pkg::PH_DATA: begin
				if (rx_s1 == dpd_pkg::CH_END) begin
					// flush held prefix bytes of a short packet
					if (pcount_q == 2'd1 || pcount_q == 2'd2) begin
						res_d[0].data = pre0;
						n_d = 3'd1;
					end
					if (pcount_q == 2'd2) begin
						res_d[1].data = pre1;
						n_d = 3'd2;
					end
				end else begin
					sum_d = sum_q + {1'b0, b7};
					if (pcount_q < 2'd2) begin
						prefix_we = 1'b1;
						pcount_d  = pcount_q + 2'd1;
					end else if (pcount_q == 2'd2) begin
						if (b7 == dpd_pkg::CH_SEQ) begin
							seq_d = 1'b1;
						end else begin
							res_d[0].data = pre0;
							res_d[1].data = pre1;
							res_d[2].data = {1'b0, b7};
							n_d = 3'd3;
						end
						pcount_d = 2'd3;
					end else begin
						res_d[0].data = {1'b0, b7};
						n_d = 3'd1;
					end
				end
			end
			dpd_pkg::PH_HIGH: begin
				high_d = dpd_pkg::hex_value(rx_s1);
			end
			dpd_pkg::PH_LOW: begin
				res_d[0].kind = dpd_pkg::KIND_TX;
				if (chk == 10'sd0) begin
					res_d[0].data = dpd_pkg::CH_ACK;
					if (seq_q) begin
						res_d[1] = '{kind: dpd_pkg::KIND_TX, data: pre0, ok: 1'b0, last: 1'b0};
						res_d[2] = '{kind: dpd_pkg::KIND_TX, data: pre1, ok: 1'b0, last: 1'b0};
						res_d[3] = '{kind: dpd_pkg::KIND_END, data: 8'd0, ok: 1'b1, last: 1'b0};
						n_d = 3'd4;
					end else begin
						res_d[1] = '{kind: dpd_pkg::KIND_END, data: 8'd0, ok: 1'b1, last: 1'b0};
						n_d = 3'd2;
					end
				end else begin
					res_d[0].data = dpd_pkg::CH_NAK;
					res_d[1] = '{kind: dpd_pkg::KIND_END, data: 8'd0, ok: 1'b0, last: 1'b0};
					n_d = 3'd2;
				end
				// start the next attempt fresh
				sum_d    = 8'd0;
				pcount_d = 2'd0;
				seq_d    = 1'b0;
				high_d   = 5'sd0;
			end
			default: begin
			end
		endcase
		// mark the final result of this byte
		for (int i = 0; i < dpd_pkg::MAX_RES; i++) begin
			res_d[i].last = (n_d == 3'(i + 1));
		end
	end

	// Hold the input request until the result buffer can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) rx_s1 <= rx_byte;
	end

	// Advance the packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dpd_pkg::PH_IDLE;
			sum_q    <= 8'd0;
			pcount_q <= 2'd0;
			seq_q    <= 1'b0;
			high_q   <= 5'sd0;
		end else if (s1_move) begin
			phase_q  <= phase_d;
			sum_q    <= sum_d;
			pcount_q <= pcount_d;
			seq_q    <= seq_d;
			high_q   <= high_d;
		end
	end

	// Hold back the first two payload bytes
	always_ff @(posedge clk) begin
		if (s1_move && prefix_we) prefix_q[pcount_q[0]] <= b7;
	end

	// Load the result buffer, drain it one result per cycle while out_stall is low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_q   <= 2'd0;
		end else if (s1_move && n_d != 3'd0) begin
			busy_q <= 1'b1;
			rd_q   <= 2'd0;
		end else if (pop_last) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && n_d != 3'd0) begin
			for (int i = 0; i < dpd_pkg::MAX_RES; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

endmodule

### design/dpd_checker.sv
// ----------------------------------------------------------------------------
// Debug packet deframer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] data,
	input logic       packet_ok,
	input logic       last
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data)
		&& $stable(packet_ok) && $stable(last))
		else $error("stalled result changed");

	// End marker carries zero data and closes its request
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == dpd_pkg::KIND_END |-> data == 8'd0 && last)
		else $error("malformed end marker");

	// Verdict only on the end marker
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != dpd_pkg::KIND_END |-> !packet_ok)
		else $error("verdict outside end marker");

	// A reply byte is never the last result of its request
	a_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == dpd_pkg::KIND_TX |-> !last)
		else $error("reply byte closed a request");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.data      (data),
	.packet_ok (packet_ok),
	.last      (last)
);
